// ----- rtl/core/alll_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alll_pkg
// Shared sizes, codes and types of the array linked list engine.
// ----------------------------------------------------------------------------
package alll_pkg;

    localparam int NODES  = 1024;
    localparam int IDX_W  = $clog2(NODES);
    localparam int NF_W   = IDX_W + 1;
    localparam int LINK_W = IDX_W + 1;
    localparam int VAL_W  = 32;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    localparam int IN_BITS  = OP_W + IDX_W + VAL_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = ST_W + IDX_W + VAL_W + 2 * LINK_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [LINK_W-1:0] NULL_LINK = '1;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    localparam logic [ST_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [ST_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [ST_W-1:0] STATUS_BAD  = 2'd2;

    typedef struct packed {
        logic signed [LINK_W-1:0] read_next;
        logic signed [LINK_W-1:0] read_prev;
        logic signed [VAL_W-1:0]  read_value;
        logic [IDX_W-1:0]         new_node;
        logic [ST_W-1:0]          status;
    } result_t;

endpackage

// ----- rtl/core/array_linked_list_engine_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_linked_list_engine_core
// Doubly linked list kept in node value, previous link and next link RAMs.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one command word: insert a value after a node, erase a
//   node, or read a node. m_tdata returns one result word per command with a
//   status, the index of a freshly inserted node, and the value and links of
//   a read node (null link = all ones).
//   Node 0 is the head sentinel; it is held in flip-flops, the other nodes
//   live in three single-port RAMs. Indices are handed out by a counter and
//   never reused.
//   Flow: a command is taken while s_tready is high and its RAM reads are
//   issued in that cycle. A read or erase then passes through ST_WR1 for the
//   read data and write-back, an insert through ST_WR1 and ST_WR2 (its link
//   writes share single RAM ports), and a rejected command skips both. In
//   ST_FIN the result is loaded into the output register, and only then does
//   the engine return to ST_IDLE to take the next command.
//   The next command is taken while a result waits in the output register;
//   if the receiver stalls, a finished command holds until that register
//   empties. Reset clears the counter to 1, the head link to null and the
//   output valid flag; RAM contents need no clearing.
// ----------------------------------------------------------------------------
module array_linked_list_engine_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // operation[1:0], node_index[11:2], value[43:12]
    input  logic [alll_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // status[1:0], new_node[11:2], read_value[43:12], read_prev[54:44],
    // read_next[65:55]
    output logic [alll_pkg::OUT_W-1:0] m_tdata
);

    localparam int IDX_W  = alll_pkg::IDX_W;
    localparam int NF_W   = alll_pkg::NF_W;
    localparam int LINK_W = alll_pkg::LINK_W;
    localparam int VAL_W  = alll_pkg::VAL_W;
    localparam int OP_W   = alll_pkg::OP_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WR1  = 3'd1;
    localparam logic [2:0] ST_WR2  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;

    logic [2:0]              state_reg, state_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [VAL_W-1:0]        val_reg, val_next;
    logic [IDX_W-1:0]        fresh_reg, fresh_next;
    logic [LINK_W-1:0]       after_reg, after_next;
    logic [NF_W-1:0]         next_free_reg, next_free_next;
    logic [LINK_W-1:0]       head_next_reg, head_next_next;
    alll_pkg::result_t       res_reg, res_next;
    alll_pkg::result_t       out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    logic [OP_W-1:0]         in_op;
    logic [IDX_W-1:0]        in_idx;
    logic [VAL_W-1:0]        in_val;
    logic                    in_bad;
    logic                    in_full;

    logic                    val_we, prev_we, next_we;
    logic [IDX_W-1:0]        val_addr, prev_addr, next_addr;
    logic [VAL_W-1:0]        val_wdata, val_rdata;
    logic [LINK_W-1:0]       prev_wdata, prev_rdata, next_wdata, next_rdata;

    logic [VAL_W-1:0]        rd_val;
    logic [LINK_W-1:0]       rd_prev, rd_next;
    logic                    load_out;

    assign in_op  = s_tdata[OP_W-1:0];
    assign in_idx = s_tdata[OP_W +: IDX_W];
    assign in_val = s_tdata[OP_W+IDX_W +: VAL_W];

    assign in_bad  = ({1'b0, in_idx} >= next_free_reg) ||
                     ((in_op == alll_pkg::OP_ERASE) && (in_idx == '0));
    assign in_full = (next_free_reg == NF_W'(alll_pkg::NODES));

    assign s_tready = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);

    // Node 0 is the sentinel: its links and value never sit in the RAMs
    assign rd_val  = (idx_reg == '0) ? '0 : val_rdata;
    assign rd_prev = (idx_reg == '0) ? alll_pkg::NULL_LINK : prev_rdata;
    assign rd_next = (idx_reg == '0) ? head_next_reg : next_rdata;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        fresh_next     = fresh_reg;
        after_next     = after_reg;
        next_free_next = next_free_reg;
        head_next_next = head_next_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        val_we     = 1'b0;
        prev_we    = 1'b0;
        next_we    = 1'b0;
        val_addr   = in_idx;
        prev_addr  = in_idx;
        next_addr  = in_idx;
        val_wdata  = val_reg;
        prev_wdata = {1'b0, idx_reg};
        next_wdata = {1'b0, fresh_reg};

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = in_op;
                    idx_next   = in_idx;
                    val_next   = in_val;
                    fresh_next = next_free_reg[IDX_W-1:0];
                    res_next   = '0;
                    if (in_op == alll_pkg::OP_NONE)
                    begin
                        state_next = ST_FIN;
                    end
                    else if (in_bad)
                    begin
                        res_next.status = alll_pkg::STATUS_BAD;
                        state_next      = ST_FIN;
                    end
                    else if ((in_op == alll_pkg::OP_INSERT) && in_full)
                    begin
                        res_next.status = alll_pkg::STATUS_FULL;
                        state_next      = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_WR1;
                    end
                end
            end
            ST_WR1:
            begin
                case (op_reg)
                    alll_pkg::OP_INSERT:
                    begin
                        after_next        = rd_next;
                        val_we            = 1'b1;
                        val_addr          = fresh_reg;
                        prev_we           = 1'b1;
                        prev_addr         = fresh_reg;
                        prev_wdata        = {1'b0, idx_reg};
                        if (idx_reg == '0)
                        begin
                            head_next_next = {1'b0, fresh_reg};
                        end
                        else
                        begin
                            next_we    = 1'b1;
                            next_addr  = idx_reg;
                            next_wdata = {1'b0, fresh_reg};
                        end
                        res_next.new_node = fresh_reg;
                        next_free_next    = next_free_reg + NF_W'(1);
                        state_next        = ST_WR2;
                    end
                    alll_pkg::OP_ERASE:
                    begin
                        // bridge the neighbours around the erased node
                        if (!rd_prev[LINK_W-1])
                        begin
                            if (rd_prev[IDX_W-1:0] == '0)
                            begin
                                head_next_next = rd_next;
                            end
                            else
                            begin
                                next_we    = 1'b1;
                                next_addr  = rd_prev[IDX_W-1:0];
                                next_wdata = rd_next;
                            end
                        end
                        if (!rd_next[LINK_W-1])
                        begin
                            prev_we    = 1'b1;
                            prev_addr  = rd_next[IDX_W-1:0];
                            prev_wdata = rd_prev;
                        end
                        state_next = ST_FIN;
                    end
                    default:
                    begin
                        res_next.read_value = rd_val;
                        res_next.read_prev  = rd_prev;
                        res_next.read_next  = rd_next;
                        state_next          = ST_FIN;
                    end
                endcase
            end
            ST_WR2:
            begin
                next_we    = 1'b1;
                next_addr  = fresh_reg;
                next_wdata = after_reg;
                if (!after_reg[LINK_W-1])
                begin
                    prev_we    = 1'b1;
                    prev_addr  = after_reg[IDX_W-1:0];
                    prev_wdata = {1'b0, fresh_reg};
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (load_out)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            next_free_reg <= NF_W'(1);
            head_next_reg <= alll_pkg::NULL_LINK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            head_next_reg <= head_next_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        idx_reg   <= idx_next;
        val_reg   <= val_next;
        fresh_reg <= fresh_next;
        after_reg <= after_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    alll_spram #(
        .WIDTH (VAL_W),
        .DEPTH (alll_pkg::NODES)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .addr  (val_addr),
        .wdata (val_wdata),
        .rdata (val_rdata)
    );

    alll_spram #(
        .WIDTH (LINK_W),
        .DEPTH (alll_pkg::NODES)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .addr  (prev_addr),
        .wdata (prev_wdata),
        .rdata (prev_rdata)
    );

    alll_spram #(
        .WIDTH (LINK_W),
        .DEPTH (alll_pkg::NODES)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .addr  (next_addr),
        .wdata (next_wdata),
        .rdata (next_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(alll_pkg::OUT_W - alll_pkg::OUT_BITS)'(0), out_reg};

`ifndef ASSERT_OFF
    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg != '0) && (next_free_reg <= NF_W'(alll_pkg::NODES)))
        else $error("node counter out of range");

    a_free_step: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg != $past(next_free_reg)) |->
        (($past(state_reg) == ST_WR1) &&
         (next_free_reg == $past(next_free_reg) + NF_W'(1))))
        else $error("node counter moved outside an insert");

    a_head_link: assert property (@(posedge clk) disable iff (!rst_n)
        head_next_reg[LINK_W-1] ? (head_next_reg == alll_pkg::NULL_LINK)
                                : ({1'b0, head_next_reg[IDX_W-1:0]} < next_free_reg))
        else $error("head link points outside the allocated nodes");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("result word loaded outside the finish step");
`endif

endmodule

// ----- rtl/core/alll_spram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alll_spram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module alll_spram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sim/list_result_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_result_monitor
// Watches both stream channels of the linked list engine. It keeps its own
// copy of the node stores and the allocation counter, predicts one result
// word per accepted command word, and compares each returned word field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module list_result_monitor
    import alll_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    // operation[1:0], node_index[11:2], value[43:12]
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    // status[1:0], new_node[11:2], read_value[43:12], read_prev[54:44],
    // read_next[65:55]
    input  logic [OUT_W-1:0] m_tdata,
    output int               mismatches,
    output int               pending
);

    localparam int REPORT_LIMIT = 10;

    logic [VAL_W-1:0]  node_value [NODES];
    logic [LINK_W-1:0] prev_link  [NODES];
    logic [LINK_W-1:0] next_link  [NODES];
    logic [NF_W-1:0]   fresh_index;
    result_t           expected_results [$];
    result_t           observed;
    result_t           predicted;
    int                fail_total = 0;

    assign mismatches = fail_total;

    // Apply one command to the shadow list and return the word it should give.
    function automatic result_t run_command(input logic [OP_W-1:0]  op,
                                            input logic [IDX_W-1:0] idx,
                                            input logic [VAL_W-1:0] val);
        result_t           res;
        logic [LINK_W-1:0] before_link;
        logic [LINK_W-1:0] after_link;
        logic [IDX_W-1:0]  fresh;
        res = '0;
        fresh = fresh_index[IDX_W-1:0];
        if (op == OP_NONE)
            return res;
        if ({1'b0, idx} >= fresh_index)
        begin
            res.status = STATUS_BAD;
        end
        else if (op == OP_INSERT)
        begin
            if (fresh_index == NF_W'(NODES))
            begin
                res.status = STATUS_FULL;
            end
            else
            begin
                after_link = next_link[idx];
                node_value[fresh] = val;
                prev_link[fresh] = {1'b0, idx};
                next_link[fresh] = after_link;
                if (after_link != NULL_LINK)
                    prev_link[after_link[IDX_W-1:0]] = {1'b0, fresh};
                next_link[idx] = {1'b0, fresh};
                res.new_node = fresh;
                fresh_index = fresh_index + 1'b1;
            end
        end
        else if (op == OP_ERASE)
        begin
            // the head sentinel cannot be unlinked
            if (idx == '0)
            begin
                res.status = STATUS_BAD;
            end
            else
            begin
                before_link = prev_link[idx];
                after_link = next_link[idx];
                if (before_link != NULL_LINK)
                    next_link[before_link[IDX_W-1:0]] = after_link;
                if (after_link != NULL_LINK)
                    prev_link[after_link[IDX_W-1:0]] = before_link;
            end
        end
        else
        begin
            res.read_value = node_value[idx];
            res.read_prev = prev_link[idx];
            res.read_next = next_link[idx];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                node_value[i] = '0;
                prev_link[i] = NULL_LINK;
                next_link[i] = NULL_LINK;
            end
            fresh_index = NF_W'(1);
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            // check the outgoing word before queueing the incoming one
            if (m_tvalid && m_tready)
            begin
                observed = result_t'(m_tdata[OUT_BITS-1:0]);
                if (expected_results.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $display("unexpected word: st %0d new %0d val %0d prev %0d next %0d",
                                 observed.status, observed.new_node, observed.read_value,
                                 observed.read_prev, observed.read_next);
                end
                else
                begin
                    predicted = expected_results.pop_front();
                    if (observed.status != predicted.status
                        || observed.new_node != predicted.new_node
                        || observed.read_value != predicted.read_value
                        || observed.read_prev != predicted.read_prev
                        || observed.read_next != predicted.read_next)
                    begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT)
                        begin
                            $display("expected: st %0d new %0d val %0d prev %0d next %0d",
                                     predicted.status, predicted.new_node,
                                     predicted.read_value, predicted.read_prev,
                                     predicted.read_next);
                            $display("actual:   st %0d new %0d val %0d prev %0d next %0d",
                                     observed.status, observed.new_node,
                                     observed.read_value, observed.read_prev,
                                     observed.read_next);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(run_command(s_tdata[OP_W-1:0],
                                                       s_tdata[OP_W +: IDX_W],
                                                       s_tdata[OP_W+IDX_W +: VAL_W]));
            pending <= expected_results.size();
        end
    end

endmodule

// ----- sim/tb_array_linked_list_engine_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_array_linked_list_engine_core
// Drives insert, erase and read commands into the linked list engine: a
// directed opening over the corner cases, then a random mix over a growing
// list. Both stream sides pause at random. A monitor beside the engine
// predicts and compares.
// ----------------------------------------------------------------------------
module tb_array_linked_list_engine_core;
    import alll_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_WORDS = 676;
    localparam int IDLE_PCT     = 30;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             steady = 1'b0;
    int               mismatches;
    int               pending;
    int               allocated = 1;
    int               quiet_cycles = 0;

    array_linked_list_engine_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    list_result_monitor u_monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // end the run if neither side moves a word for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_array_linked_list_engine_core failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(11))
            0: return '0;
            1: return '1;
            2: return {1'b0, {(VAL_W-1){1'b1}}};
            3: return {1'b1, {(VAL_W-1){1'b0}}};
            default: return $urandom();
        endcase
    endfunction

    // Any allocated node (not the head if skip_head and others exist), often the newest one.
    function automatic int pick_node(input bit skip_head);
        int lo;
        lo = (skip_head && allocated > 1) ? 1 : 0;
        if ($urandom_range(4) == 0)
            return allocated - 1;
        return $urandom_range(lo, allocated - 1);
    endfunction

    task automatic send_word(input logic [OP_W-1:0]  op,
                             input int               idx,
                             input logic [VAL_W-1:0] val);
        if (op == OP_INSERT && idx < allocated && allocated < NODES)
            allocated++;
        if (!steady)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_W'({val, idx[IDX_W-1:0], op});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_random_command();
        int                pick;
        logic [OP_W-1:0]   op_code;
        pick = $urandom_range(99);
        op_code = OP_W'($urandom_range(2));
        if (pick < 55)
            send_word(OP_INSERT, pick_node(1'b0), pick_value());
        else if (pick < 75)
            send_word(OP_READ, pick_node(1'b0), pick_value());
        else if (pick < 92)
            send_word(OP_ERASE, pick_node(1'b1), pick_value());
        else if (pick < 97 && allocated < NODES)
            send_word(op_code, $urandom_range(allocated, NODES - 1), pick_value());
        else
            send_word(OP_NONE, $urandom_range(NODES - 1), $urandom());
    endtask

    initial
    begin
        int n;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, rejected commands and the unused code
        send_word(OP_READ, 0, '0);
        send_word(OP_INSERT, NODES - 1, 32'h7FFF_FFFF);
        send_word(OP_ERASE, 0, '0);
        send_word(OP_ERASE, 1, '0);
        send_word(OP_NONE, NODES - 1, '1);
        send_word(OP_READ, 1, '0);
        // build 2 -> 4 -> 1 -> 3
        send_word(OP_INSERT, 0, 32'h8000_0000);
        send_word(OP_INSERT, 0, 32'h7FFF_FFFF);
        send_word(OP_INSERT, 1, 32'hFFFF_FFFF);
        send_word(OP_INSERT, 2, 32'h0000_0000);
        send_word(OP_READ, 0, '0);
        send_word(OP_READ, 2, '0);
        send_word(OP_READ, 4, '0);
        // unlink a middle node, then work on its stale links
        send_word(OP_ERASE, 4, '0);
        send_word(OP_READ, 2, '0);
        send_word(OP_ERASE, 4, '0);
        send_word(OP_READ, 4, '0);
        send_word(OP_INSERT, 4, 32'h5A5A_5A5A);
        send_word(OP_READ, 5, '0);
        // drop the tail and the first node
        send_word(OP_ERASE, 3, '0);
        send_word(OP_ERASE, 2, '0);
        send_word(OP_READ, 0, '0);
        send_word(OP_READ, 1, '0);
        send_word(OP_READ, 6, '0);

        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == 250)
                steady <= 1'b1;
            if (n == 400)
                steady <= 1'b0;
            send_random_command();
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_array_linked_list_engine_core passed");
        else
            $display("tb_array_linked_list_engine_core failed");
        $finish;
    end

endmodule
